// ----- design/assert_macros.svh -----
// assertion helper macros used by the design module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define NGHF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define NGHF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- design/nghf_pkg.sv -----
// ---------------------------------------------------------------------------
// nghf_pkg
// Types, constants and tables shared by the noise gate with hold and fade.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package nghf_pkg;
  localparam int CHUNK_SIZE_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ATT_W  = 24;
  localparam int GAIN_W = 17;
  localparam int CFG_W  = 23;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ENV_COEFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;

  localparam logic [15:0] ENV_COEFF_RST = 16'd136;
  localparam logic [22:0] THRESHOLD_RST = 23'd33396;
  localparam logic [21:0] HOLD_RST      = 22'd48000;
  localparam logic [22:0] FADE_RST      = 23'd140;
  localparam logic [22:0] RELEASE_RST   = 23'd16777;

  localparam logic signed [ATT_W-1:0] ATT_MIN    = -24'sd6291456;
  localparam logic signed [ATT_W-1:0] ATT_CUTOFF = -24'sd6225920;
  localparam logic [13:0] LOG2_DB_Q16 = 14'd10885;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] detector_sample;
    logic signed [SAMPLE_BITS_DEF-1:0] audio_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] gated_sample;
    logic signed [ATT_W-1:0]           gate_attenuation;
    logic                              gate_below;
  } out_beat_t;

  // Q30 factors 2^-(2^-(j+1))
  function automatic logic [30:0] exp_tab(input logic [2:0] j);
    logic [30:0] v;
    case (j)
      3'd0: v = 31'd759250125;
      3'd1: v = 31'd902905651;
      3'd2: v = 31'd984625594;
      3'd3: v = 31'd1028218693;
      3'd4: v = 31'd1050733751;
      3'd5: v = 31'd1062175491;
      3'd6: v = 31'd1067942999;
      3'd7: v = 31'd1070838486;
      default: v = 31'd0;
    endcase
    return v;
  endfunction
endpackage

// ----- design/noise_gate_hold_fade.sv -----
// ---------------------------------------------------------------------------
// noise_gate_hold_fade
// Chunked noise gate with hold time, fade and release, and a gain ramp.
// ---------------------------------------------------------------------------
// Usage: in_valid/in_stall carry one beat of detector and audio samples;
// out_valid/out_stall return one beat per input beat, holding the gated
// audio from one chunk earlier, the attenuation and the below flag.
// The cfg_ port writes a register at any edge with cfg_we high.
// Each beat is worked by one serial sequencer: the follower multiply, the
// level update, the ramp divide by CHUNK_SIZE in a serial restoring
// divider, the sample * gain multiply, and saturation and output. A new
// beat is taken only after the last one has reached the output register.
// The last beat of a chunk also runs the gain update: a setup step, a
// 24 x 14 shift-and-add, eight table steps and one series step, and a
// rounding step.
// in_stall is high while a beat is worked. A result waits in the output
// register while out_stall is high and holds its beat unchanged; the next
// beat may be taken meanwhile and waits in its last step until it is free.
// Reset sets the sequencer, the gate state and the configuration
// registers to their reset values; the delay line is a memory whose
// contents are cleared by a sweep of CHUNK_SIZE entries after reset,
// during which in_stall stays high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module noise_gate_hold_fade #(
  parameter int CHUNK_SIZE = nghf_pkg::CHUNK_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nghf_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nghf_pkg::out_beat_t               out_data,
  input  logic                              cfg_we,
  input  logic [nghf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nghf_pkg::CFG_W-1:0]        cfg_data
);
  localparam int SB   = nghf_pkg::SAMPLE_BITS_DEF;
  localparam int PW   = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;
  localparam int LW   = SB + 17;           // level width
  localparam int AW   = nghf_pkg::ATT_W;
  localparam int GW   = nghf_pkg::GAIN_W;
  localparam int DW   = GW + 1;            // signed gain delta
  localparam int QW   = DW + PW + 1;       // delta * p
  localparam int YW   = SB + GW + 2;       // sample * gain

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FOLL  = 4'd2;
  localparam logic [3:0] S_DELTA = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_AMUL  = 4'd5;
  localparam logic [3:0] S_SAT   = 4'd6;
  localparam logic [3:0] S_CHUNK = 4'd7;
  localparam logic [3:0] S_LOGM  = 4'd8;
  localparam logic [3:0] S_EXPM  = 4'd9;
  localparam logic [3:0] S_GFIN  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // configuration registers
  logic [15:0] env_coeff_r;
  logic [22:0] threshold_r;
  logic [21:0] hold_r;
  logic [22:0] fade_r;
  logic [22:0] release_r;

  // block state
  logic [3:0]          state_r;
  logic [LW-1:0]       level_r;
  logic [23:0]         below_time_r;
  logic signed [AW-1:0] att_r;
  logic [GW-1:0]       gain_start_r, gain_end_r;
  logic                below_r;
  logic [PW-1:0]       pos_r;
  logic signed [SB-1:0] delay_mem [CHUNK_SIZE];
  logic signed [SB-1:0] delay_rd_r;
  logic signed [SB-1:0] det_r, aud_r;

  // serial datapath
  logic [5:0]          cnt_r;
  logic [LW-1:0]       diff_r;       // multiplicand for follower and |att| * log2 factor
  logic [LW+16-1:0]    acc_r;        // shared accumulator
  logic                up_r;
  logic signed [QW-1:0] num_r;       // ramp numerator
  logic [QW-1:0]       rem_r, quo_r, nmag_r;
  logic signed [GW+1:0] gain_r;      // ramped gain
  logic [62:0]         pacc_r;       // exp product accumulator
  logic [30:0]         mcand_r, mplier_r;
  logic [31:0]         frac_r;
  logic [3:0]          nexp_r;
  logic                zero_r;
  logic [3:0]          estep_r;
  logic signed [SB-1:0] gated_r;     // saturated sample awaiting output
  logic                out_valid_r;
  nghf_pkg::out_beat_t out_r;
  logic [PW:0]         clr_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_coeff_r <= nghf_pkg::ENV_COEFF_RST;
      threshold_r <= nghf_pkg::THRESHOLD_RST;
      hold_r      <= nghf_pkg::HOLD_RST;
      fade_r      <= nghf_pkg::FADE_RST;
      release_r   <= nghf_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nghf_pkg::REG_ENV_COEFF: env_coeff_r <= cfg_data[15:0];
        nghf_pkg::REG_THRESHOLD: threshold_r <= cfg_data[22:0];
        nghf_pkg::REG_HOLD:      hold_r      <= cfg_data[21:0];
        nghf_pkg::REG_FADE:      fade_r      <= cfg_data;
        nghf_pkg::REG_RELEASE:   release_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // combinational helpers
  logic [SB-1:0]       det_mag;
  logic [LW-1:0]       mag_q;
  logic signed [AW+1:0] att_sum, att_clamped_w;
  logic [24:0]         bt_sum;
  logic [23:0]         bt_new;
  logic                below_now;
  logic [QW-1:0]       rem_try;
  logic [30:0]         series_fac;
  logic [53:0]         series_prod;
  logic signed [YW-1:0] y_full;
  logic signed [YW-1:0] y_shift;

  always_comb begin
    det_mag = det_r[SB-1] ? SB'(-det_r) : SB'(det_r);
    mag_q   = {1'b0, det_mag, 16'd0};
    below_now = level_r < {2'b0, threshold_r, 16'd0};
    bt_sum  = {1'b0, below_time_r} + 25'(CHUNK_SIZE);
    bt_new  = below_now ? (bt_sum[24] ? 24'hFFFFFF : bt_sum[23:0]) : 24'd0;
    if (bt_new > {2'b0, hold_r})
      att_sum = (AW+2)'(att_r) - (AW+2)'(signed'({1'b0, fade_r}));
    else
      att_sum = (AW+2)'(att_r) + (AW+2)'(signed'({1'b0, release_r}));
    if (att_sum < (AW+2)'(nghf_pkg::ATT_MIN)) att_clamped_w = (AW+2)'(nghf_pkg::ATT_MIN);
    else if (att_sum > 0) att_clamped_w = '0;
    else att_clamped_w = att_sum;
    rem_try = {rem_r[QW-2:0], nmag_r[QW-1]};
    series_prod = 54'(frac_r[23:0]) * 54'(nghf_pkg::LN2_Q30);
    series_fac  = 31'h40000000 - 31'(series_prod[53:24]);
    y_full  = YW'(acc_r[YW-1:0]) + YW'(32768);
    y_shift = y_full >>> 16;
  end

  // delay line memory: clear sweep, write of audio after read
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR)
      delay_mem[clr_r[PW-1:0]] <= '0;
    else if (state_r == S_SAT)
      delay_mem[pos_r] <= aud_r;
    delay_rd_r <= delay_mem[pos_r];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      level_r      <= '0;
      below_time_r <= '0;
      att_r        <= '0;
      gain_start_r <= nghf_pkg::GAIN_UNITY;
      gain_end_r   <= nghf_pkg::GAIN_UNITY;
      below_r      <= 1'b0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (PW+1)'(CHUNK_SIZE - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            det_r   <= in_data.detector_sample;
            aud_r   <= in_data.audio_sample;
            state_r <= S_FOLL;
            cnt_r   <= '0;
            acc_r   <= '0;
          end
        end
        // follower: serial coeff * |diff|
        S_FOLL: begin
          if (cnt_r == 6'd0) begin
            up_r   <= mag_q >= level_r;
            diff_r <= (mag_q >= level_r) ? mag_q - level_r : level_r - mag_q;
            cnt_r  <= 6'd1;
          end else begin
            if (env_coeff_r[cnt_r[3:0] - 4'd1])
              acc_r <= acc_r + ((LW+16)'(diff_r) << (cnt_r[3:0] - 4'd1));
            if (cnt_r == 6'd16) begin
              state_r <= S_DELTA;
              cnt_r   <= '0;
            end else cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DELTA: begin
          if (up_r) level_r <= level_r + LW'(acc_r >> 16);
          else      level_r <= level_r - LW'(acc_r >> 16);
          num_r  <= QW'(signed'({1'b0, gain_end_r}) - signed'({1'b0, gain_start_r}))
                    * QW'({1'b0, pos_r});
          state_r <= S_DIV;
          cnt_r   <= '0;
        end
        // serial restoring divide of |num| by CHUNK_SIZE
        S_DIV: begin
          if (cnt_r == 6'd0) begin
            nmag_r <= num_r[QW-1] ? QW'(-num_r) : QW'(num_r);
            rem_r  <= '0;
            quo_r  <= '0;
            cnt_r  <= 6'd1;
          end else begin
            if (rem_try >= QW'(CHUNK_SIZE)) begin
              rem_r <= rem_try - QW'(CHUNK_SIZE);
              quo_r <= {quo_r[QW-2:0], 1'b1};
            end else begin
              rem_r <= rem_try;
              quo_r <= {quo_r[QW-2:0], 1'b0};
            end
            nmag_r <= nmag_r << 1;
            if (cnt_r == 6'(QW)) begin
              state_r <= S_AMUL;
              cnt_r   <= '0;
            end else cnt_r <= cnt_r + 1'b1;
          end
        end
        // serial sample * gain
        S_AMUL: begin
          if (cnt_r == 6'd0) begin
            gain_r <= (GW+2)'(signed'({1'b0, gain_start_r}))
                      + (num_r[QW-1] ? -(GW+2)'(quo_r) : (GW+2)'(quo_r));
            acc_r  <= '0;
            cnt_r  <= 6'd1;
          end else begin
            if (gain_r[cnt_r[4:0] - 5'd1])
              acc_r <= acc_r + ((LW+16)'(signed'(delay_rd_r)) << (cnt_r[4:0] - 5'd1));
            if (cnt_r == 6'(GW)) begin
              state_r <= S_SAT;
              cnt_r   <= '0;
            end else cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SAT: begin
          if (y_shift > YW'((1 << (SB-1)) - 1))
            gated_r <= SB'((1 << (SB-1)) - 1);
          else if (y_shift < -YW'(1 << (SB-1)))
            gated_r <= SB'(-(1 << (SB-1)));
          else gated_r <= SB'(y_shift);
          if (pos_r == PW'(CHUNK_SIZE - 1)) begin
            pos_r   <= '0;
            state_r <= S_CHUNK;
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= S_OUT;
          end
        end
        S_CHUNK: begin
          below_time_r <= bt_new;
          below_r      <= below_now;
          att_r        <= AW'(att_clamped_w);
          gain_start_r <= gain_end_r;
          zero_r       <= att_clamped_w <= (AW+2)'(nghf_pkg::ATT_CUTOFF);
          acc_r        <= '0;
          diff_r       <= LW'(-AW'(att_clamped_w));
          cnt_r        <= '0;
          state_r      <= S_LOGM;
        end
        // serial |att| * log2 factor
        S_LOGM: begin
          if (nghf_pkg::LOG2_DB_Q16[cnt_r[3:0]])
            acc_r <= acc_r + ((LW+16)'(diff_r) << cnt_r[3:0]);
          if (cnt_r == 6'd13) begin
            state_r <= S_EXPM;
            estep_r <= '0;
            cnt_r   <= '0;
          end else cnt_r <= cnt_r + 1'b1;
        end
        // eight table steps and one series step
        S_EXPM: begin
          if (cnt_r == 6'd0) begin
            if (estep_r == 4'd0) begin
              nexp_r  <= acc_r[35:32];
              if (acc_r[LW+15:36] != '0) zero_r <= 1'b1;
              frac_r  <= acc_r[31:0];
              mcand_r <= 31'h40000000;
            end
            pacc_r <= '0;
            mplier_r <= (estep_r == 4'd8) ? series_fac
                      : nghf_pkg::exp_tab(estep_r[2:0]);
            cnt_r <= 6'd1;
          end else begin
            if (mplier_r[cnt_r[4:0] - 5'd1])
              pacc_r <= pacc_r + (63'(mcand_r) << (cnt_r[4:0] - 5'd1));
            if (cnt_r == 6'd31) begin
              cnt_r <= '0;
              estep_r <= estep_r + 1'b1;
              if (estep_r == 4'd8) state_r <= S_GFIN;
            end else cnt_r <= cnt_r + 1'b1;
          end
          // keep the table product only where its fraction bit is set
          if (cnt_r == 6'd0 && estep_r != 4'd0) begin
            if (frac_r[5'(6'd32 - {2'b0, estep_r})])
              mcand_r <= 31'(pacc_r >> 30);
          end
        end
        S_GFIN: begin
          if (zero_r) gain_end_r <= '0;
          else gain_end_r <= GW'((63'(pacc_r >> 30) + (63'(1) << (13 + nexp_r)))
                                 >> (14 + nexp_r));
          state_r <= S_OUT;
        end
        // wait for the output register to be free
        S_OUT: begin
          if (!out_valid_r) begin
            out_r.gated_sample     <= gated_r;
            out_r.gate_attenuation <= att_r;
            out_r.gate_below       <= below_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `NGHF_ASSERT(a_one_beat, clk, rst_n, (in_valid && !in_stall) |=> (state_r == S_FOLL), "accepted beat did not start follower")
  `NGHF_ASSERT(a_out_hold, clk, rst_n, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)), "stalled result changed")
  `NGHF_ASSERT(a_att_range, clk, rst_n, (att_r <= 0), "attenuation above zero")
endmodule

// ----- test/noise_gate_hold_fade_test.sv -----
// ---------------------------------------------------------------------------
// noise_gate_hold_fade_test
// Self-checking bench for the chunked noise gate: a bit-exact predictor of
// the follower, the per-chunk hold/fade/release update, the gain table and
// the delayed ramp runs beside the block, and every output beat is compared
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module noise_gate_hold_fade_test;

  localparam int CHUNK = nghf_pkg::CHUNK_SIZE_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  nghf_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nghf_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [nghf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nghf_pkg::CFG_W-1:0] cfg_data = '0;

  noise_gate_hold_fade u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [15:0] p_coeff;
  logic [22:0] p_thresh;
  logic [21:0] p_hold;
  logic [22:0] p_fade;
  logic [22:0] p_release;
  longint unsigned p_level;
  longint unsigned p_below_time;
  longint p_att;
  longint p_gain_start;
  longint p_gain_end;
  bit p_below;
  int p_pos;
  longint p_delay[CHUNK];

  nghf_pkg::in_beat_t pending_beats[$];
  nghf_pkg::out_beat_t gated_expected[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int chunks_seen = 0;
  int faded_beats = 0;
  bit stall_on = 1'b1;
  bit send_idle_on = 1'b1;
  int long_hold = 0;
  int watchdog = 0;
  int send_gap = 0;

  function automatic longint unsigned gain_of_att(longint att);
    longint unsigned m, f, acc, lo, fac;
    int unsigned n;
    longint unsigned tab[8];
    tab = '{759250125, 902905651, 984625594, 1028218693,
            1050733751, 1062175491, 1067942999, 1070838486};
    if (att <= -6225920) return 0;
    if (att > 0) att = 0;
    m = longint'(-att) * 10885;
    n = 32'(m >> 32);
    if (n > 15) return 0;
    f = m & 64'hFFFF_FFFF;
    acc = 64'd1 << 30;
    for (int j = 0; j < 8; j++)
      if ((f >> (31 - j)) & 1) acc = (acc * tab[j]) >> 30;
    lo = f & 64'hFF_FFFF;
    fac = (64'd1 << 30) - ((lo * 744261118) >> 24);
    acc = (acc * fac) >> 30;
    return (acc + (64'd1 << (13 + n))) >> (14 + n);
  endfunction

  function automatic void gate_reset();
    p_coeff = nghf_pkg::ENV_COEFF_RST; p_thresh = nghf_pkg::THRESHOLD_RST;
    p_hold = nghf_pkg::HOLD_RST;
    p_fade = nghf_pkg::FADE_RST; p_release = nghf_pkg::RELEASE_RST;
    p_level = 0; p_below_time = 0; p_att = 0;
    p_gain_start = 65536; p_gain_end = 65536;
    p_below = 0; p_pos = 0;
    foreach (p_delay[i]) p_delay[i] = 0;
  endfunction

  // one beat through the predictor
  function automatic nghf_pkg::out_beat_t gate_predict(nghf_pkg::in_beat_t b);
    nghf_pkg::out_beat_t r;
    longint det, aud, g, y, prod;
    longint unsigned mag;
    bit below;
    det = longint'(b.detector_sample);
    aud = longint'(b.audio_sample);
    mag = longint'(det < 0 ? -det : det) << 16;
    if (mag >= p_level) p_level += ((mag - p_level) * p_coeff) >> 16;
    else p_level -= ((p_level - mag) * p_coeff) >> 16;
    g = p_gain_start + (p_gain_end - p_gain_start) * p_pos / CHUNK;
    prod = p_delay[p_pos] * g + 32768;
    y = prod >>> 16;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    p_delay[p_pos] = aud;
    p_pos++;
    if (p_pos >= CHUNK) begin
      p_pos = 0;
      chunks_seen++;
      below = p_level < (longint'(p_thresh) << 16);
      if (below) begin
        p_below_time += CHUNK;
        if (p_below_time > 16777215) p_below_time = 16777215;
      end else begin
        p_below_time = 0;
      end
      p_below = below;
      if (p_below_time > p_hold) p_att -= p_fade;
      else p_att += p_release;
      if (p_att < -6291456) p_att = -6291456;
      if (p_att > 0) p_att = 0;
      p_gain_start = p_gain_end;
      p_gain_end = gain_of_att(p_att);
    end
    if (p_att < 0) faded_beats++;
    r.gated_sample = y[23:0];
    r.gate_attenuation = p_att[23:0];
    r.gate_below = p_below;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at beat %0d: got %0d, want %0d", what, beats_out, got, want);
    errors++;
  endtask

  // driver: offers queued beats, with random idle gaps while enabled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        gated_expected.push_back(gate_predict(in_data));
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (send_idle_on && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random bursts, and one long hold-off
  int stall_left = 0;
  always @(posedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    nghf_pkg::out_beat_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (gated_expected.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = gated_expected.pop_front();
        if (out_data.gated_sample !== w.gated_sample)
          report_mismatch("gated_sample", out_data.gated_sample, w.gated_sample);
        if (out_data.gate_attenuation !== w.gate_attenuation)
          report_mismatch("gate_attenuation", out_data.gate_attenuation, w.gate_attenuation);
        if (out_data.gate_below !== w.gate_below)
          report_mismatch("gate_below", out_data.gate_below, w.gate_below);
      end
      beats_out++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog > WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [nghf_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[nghf_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      nghf_pkg::REG_ENV_COEFF: p_coeff = val[15:0];
      nghf_pkg::REG_THRESHOLD: p_thresh = val[22:0];
      nghf_pkg::REG_HOLD:      p_hold = val[21:0];
      nghf_pkg::REG_FADE:      p_fade = val[22:0];
      nghf_pkg::REG_RELEASE:   p_release = val[22:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || gated_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // loud chunk, quiet chunks, loud again
  task automatic queue_gate_cycle(int quiet_chunks, int full_scale);
    nghf_pkg::in_beat_t b;
    for (int i = 0; i < CHUNK * (2 + quiet_chunks); i++) begin
      b.audio_sample = 24'($urandom);
      if (i < CHUNK || i >= CHUNK * (1 + quiet_chunks))
        b.detector_sample = full_scale ? 24'sh800000 : 24'($urandom);
      else
        b.detector_sample = 24'(int'($urandom_range(0, 15)) - 8);
      pending_beats.push_back(b);
    end
  endtask

  initial begin
    nghf_pkg::in_beat_t b;
    gate_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // fast gate: short hold, big fade, full coefficient
    write_reg(nghf_pkg::REG_ENV_COEFF, 65535);
    write_reg(nghf_pkg::REG_THRESHOLD, 8000);
    write_reg(nghf_pkg::REG_HOLD, 0);
    write_reg(nghf_pkg::REG_FADE, 6291456);
    write_reg(nghf_pkg::REG_RELEASE, 6291456);
    // directed extremes
    for (int i = 0; i < 20; i++) begin
      b.detector_sample = (i % 4 == 0) ? 24'sh7FFFFF : (i % 4 == 1) ? 24'sh800000 :
                          (i % 4 == 2) ? 24'sh000000 : 24'shFFFFFF;
      b.audio_sample = (i % 2) ? 24'sh800000 : 24'sh7FFFFF;
      pending_beats.push_back(b);
    end
    queue_gate_cycle(1, 1);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    long_hold = 400;
    queue_gate_cycle(1, 0);
    wait_idle();

    // gentler gates: first one that never fades, then partial fades to exercise the gain curve
    write_reg(nghf_pkg::REG_ENV_COEFF, 1);
    write_reg(nghf_pkg::REG_THRESHOLD, 0);
    write_reg(nghf_pkg::REG_HOLD, 4194303);
    write_reg(nghf_pkg::REG_FADE, 1);
    write_reg(nghf_pkg::REG_RELEASE, 1);
    queue_gate_cycle(0, 0);
    wait_idle();

    write_reg(nghf_pkg::REG_ENV_COEFF, 40000);
    write_reg(nghf_pkg::REG_THRESHOLD, 8388607);
    write_reg(nghf_pkg::REG_HOLD, 64);
    write_reg(nghf_pkg::REG_FADE, 150000);
    write_reg(nghf_pkg::REG_RELEASE, 900000);
    queue_gate_cycle(3, 0);
    wait_idle();

    // random settings, last part with no idling
    for (int k = 0; k < 2; k++) begin
      write_reg(nghf_pkg::REG_ENV_COEFF, $urandom_range(1, 65535));
      write_reg(nghf_pkg::REG_THRESHOLD, $urandom_range(0, 600000));
      write_reg(nghf_pkg::REG_HOLD, $urandom_range(0, 200));
      write_reg(nghf_pkg::REG_FADE, $urandom_range(1, 2000000));
      write_reg(nghf_pkg::REG_RELEASE, $urandom_range(1, 2000000));
      if (k == 1) begin
        stall_on = 1'b0;
        send_idle_on = 1'b0;
      end
      queue_gate_cycle($urandom_range(0, 1), 0);
      wait_idle();
    end

    $display("%0d beats sent, %0d checked over %0d chunk updates, %0d while attenuated",
             beats_in, beats_out, chunks_seen, faded_beats);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
